// ===== rtl/pc3_pkg.sv =====
// Shared constants and types of the 3x3 pixel convolution block.
`timescale 1ns / 1ps

package pc3_pkg;

	localparam int MAX_COLS_DEF = 1024;

	localparam int PIX_W    = 8;
	localparam int INT_W    = 3;
	localparam int TAP_NUM  = 9;
	localparam int WEIGHT_W = 8;
	localparam int KERNEL_W = TAP_NUM * WEIGHT_W;
	localparam int SUM_W    = 8;

	localparam int ROW_W     = 11;
	localparam int KROW_W    = 24;
	localparam int DIV_W     = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH     = 3'd0,
		REG_KERNEL_TOP    = 3'd1,
		REG_KERNEL_MIDDLE = 3'd2,
		REG_KERNEL_BOTTOM = 3'd3,
		REG_SUM_DIVISOR   = 3'd4
	} pc3_reg_t;

	// Wrapped window sum handed from the front to the queue.
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} pc3_push_t;

	// Head of the queue as seen by the divider.
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} pc3_head_t;

endpackage

// ===== rtl/pc3_stream_if.sv =====
// Pixel and result stream interfaces of the 3x3 pixel convolution block.
`timescale 1ns / 1ps

interface pc3_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       image_start;

	modport source (output valid, output pixel, output image_start, input ready);
	modport sink (input valid, input pixel, input image_start, output ready);
endinterface

interface pc3_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] filtered_pixel;

	modport source (output valid, output filtered_pixel, input ready);
	modport sink (input valid, input filtered_pixel, output ready);
endinterface

// ===== rtl/pixel_convolution_3x3_core.sv =====
// Top level of the 3x3 pixel convolution block: registers, front end, queue, divider.
`timescale 1ns / 1ps
// Throughput: one pixel per cycle, set by the single write port of the line store
// and the two-word window fetch from it, while the queue has room; intake is held
// back under output back-pressure. A result passes the front end, the queue and
// the divider pipe to the output register. Reset: clears the pixel index, line
// store pointer, queue and all valid bits and loads the register defaults; the line
// store is not cleared, older entries are masked by the pixel index.

module pixel_convolution_3x3_core import pc3_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pc3_pixel_if.sink             pixels,
	pc3_result_if.source          filtered,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [ROW_W-1:0]  row_width_q;
	logic [KROW_W-1:0] kernel_top_q, kernel_middle_q, kernel_bottom_q;
	logic [DIV_W-1:0]  sum_divisor_q;

	pc3_push_t              push;
	pc3_head_t              head;
	logic                   pop;
	logic [QUEUE_LVL_W-1:0] queue_level;

	// Register file: write only, unknown indexes drop the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q     <= ROW_W'(1024);
			kernel_top_q    <= '0;
			kernel_middle_q <= '0;
			kernel_bottom_q <= '0;
			sum_divisor_q   <= DIV_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW_WIDTH:     row_width_q     <= wr_data[ROW_W-1:0];
				REG_KERNEL_TOP:    kernel_top_q    <= wr_data[KROW_W-1:0];
				REG_KERNEL_MIDDLE: kernel_middle_q <= wr_data[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kernel_bottom_q <= wr_data[KROW_W-1:0];
				REG_SUM_DIVISOR:   sum_divisor_q   <= wr_data[DIV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: index the pixel, store it, fetch the window and form the
	// wrapped sum. Its intake is held back by credit against the queue, so
	// its two stages never stall.
	pc3_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.row_width   (row_width_q),
		.kernel      ({kernel_bottom_q, kernel_middle_q, kernel_top_q}),
		.queue_level (queue_level),
		.push        (push)
	);

	// Queue: decouples the front end from output back-pressure.
	pc3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (queue_level)
	);

	// Back end: divide by the configured divisor; the last stage is the
	// output register, and the whole pipe holds while it waits.
	pc3_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sum_divisor (sum_divisor_q),
		.head        (head),
		.pop         (pop),
		.filtered    (filtered)
	);

endmodule

// ===== rtl/pc3_front.sv =====
// Front end: pixel index, line store, window fetch and wrapped kernel sum.
`timescale 1ns / 1ps

module pc3_front import pc3_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pc3_pixel_if.sink              pixels,
	input  logic [ROW_W-1:0]       row_width,
	input  logic [KERNEL_W-1:0]    kernel,
	input  logic [QUEUE_LVL_W-1:0] queue_level,
	output pc3_push_t              push
);

	localparam int CNT_W  = $clog2(2 * MAX_COLS + 3);
	localparam int ADDR_W = $clog2(2 * MAX_COLS + 1);
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int CW     = (CNT_W > ROW_W) ? CNT_W : ROW_W;
	localparam int WORD_W = 3 * INT_W;
	localparam int OCC_W  = QUEUE_LVL_W + 1;

	// line store word at position p: intensities of p-2, p-1, p (p lowest)
	logic [WORD_W-1:0] mem [DEPTH];

	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] wp_q;
	logic [INT_W-1:0]  prev1_q, prev2_q;

	logic                valid_s1;
	logic [WORD_W-1:0]   row0_s1, row1_s1, row2_s1;
	logic [TAP_NUM-1:0]  mask_s1;
	logic                valid_s2;
	logic [SUM_W-1:0]    sum_s2;

	logic [CW-1:0]     rw_ext, w_full;
	logic [CNT_W-1:0]  w, w2, top, idx, count_nxt;
	logic [CNT_W-1:0]  ks [TAP_NUM];
	logic [TAP_NUM-1:0] mask;
	logic              accept, has_result;
	logic [INT_W-1:0]  cur;
	logic [WORD_W-1:0] word;
	logic [ADDR_W-1:0] wp_nxt, rd_addr1, rd_addr2;
	logic [OCC_W-1:0]  occupancy;
	logic [3*WORD_W-1:0] taps;
	logic [SUM_W-1:0]  sum;

	// Clamp the row width into 1..MAX_COLS.
	always_comb begin
		rw_ext = CW'(row_width);
		if (rw_ext == '0) begin
			w_full = CW'(1);
		end else if (rw_ext > CW'(MAX_COLS)) begin
			w_full = CW'(MAX_COLS);
		end else begin
			w_full = rw_ext;
		end
		w   = CNT_W'(w_full);
		w2  = CNT_W'({w, 1'b0});
		top = w2 + CNT_W'(2);
	end

	assign occupancy = OCC_W'(queue_level) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign pixels.ready = occupancy < OCC_W'(QUEUE_DEPTH);
	assign accept = pixels.valid && pixels.ready;

	always_comb begin
		idx = pixels.image_start ? '0 : count_q;
		if (idx > top) begin
			idx = top;
		end
		count_nxt  = (idx < top) ? idx + CNT_W'(1) : top;
		has_result = idx >= w + CNT_W'(1);
	end

	// Tap t sits k back and takes weight t.
	always_comb begin
		ks[0] = '0;
		ks[1] = CNT_W'(1);
		ks[2] = CNT_W'(2);
		ks[3] = w;
		ks[4] = w + CNT_W'(1);
		ks[5] = w + CNT_W'(2);
		ks[6] = w2;
		ks[7] = w2 + CNT_W'(1);
		ks[8] = w2 + CNT_W'(2);
		for (int t = 0; t < TAP_NUM; t++) begin
			mask[t] = ks[t] <= idx;
		end
	end

	assign cur      = pixels.pixel[PIX_W-1 -: INT_W];
	assign word     = {prev2_q, prev1_q, cur};
	assign wp_nxt   = wp_q + ADDR_W'(1);
	assign rd_addr1 = wp_nxt - ADDR_W'(w);
	assign rd_addr2 = wp_nxt - ADDR_W'(w2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wp_q     <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
				wp_q    <= wp_nxt;
			end
			valid_s1 <= accept && has_result;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_nxt] <= word;
			row1_s1     <= mem[rd_addr1];
			row2_s1     <= mem[rd_addr2];
			row0_s1     <= word;
			mask_s1     <= mask;
			prev1_q     <= cur;
			prev2_q     <= prev1_q;
		end
		sum_s2 <= sum;
	end

	// Multiply each tap by its weight and sum modulo 256.
	always_comb begin
		logic [INT_W-1:0] tv;
		taps = {row2_s1, row1_s1, row0_s1};
		sum  = '0;
		for (int t = 0; t < TAP_NUM; t++) begin
			tv  = mask_s1[t] ? taps[INT_W*t +: INT_W] : '0;
			sum = sum + SUM_W'({5'b0, tv} * kernel[WEIGHT_W*t +: WEIGHT_W]);
		end
	end

	assign push.valid = valid_s2;
	assign push.sum   = sum_s2;

endmodule

// ===== rtl/pc3_queue.sv =====
// Short queue of wrapped sums between the front end and the divider.
`timescale 1ns / 1ps

module pc3_queue import pc3_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pc3_push_t              push,
	input  logic                   pop,
	output pc3_head_t              head,
	output logic [QUEUE_LVL_W-1:0] level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [SUM_W-1:0] store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;
	logic do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + QUEUE_LVL_W'(push.valid) - QUEUE_LVL_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			store_q[wr_ptr_q] <= push.sum;
		end
	end

	assign head.valid = level_q != '0;
	assign head.sum   = store_q[rd_ptr_q];
	assign level      = level_q;

endmodule

// ===== rtl/pc3_back.sv =====
// Back end: pipelined restoring divider, two quotient bits per stage.
`timescale 1ns / 1ps

module pc3_back import pc3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIV_W-1:0] sum_divisor,
	input  pc3_head_t        head,
	output logic             pop,
	pc3_result_if.source     filtered
);

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] nq;
	} div_t;

	function automatic div_t div_step2(div_t cur, logic [DIV_W-1:0] d);
		div_t      nx;
		logic [SUM_W:0] r9;
		nx = cur;
		for (int i = 0; i < 2; i++) begin
			r9    = {nx.rem, nx.nq[SUM_W-1]};
			nx.nq = {nx.nq[SUM_W-2:0], 1'b0};
			if (r9 >= {1'b0, d}) begin
				nx.rem   = SUM_W'(r9 - {1'b0, d});
				nx.nq[0] = 1'b1;
			end else begin
				nx.rem = r9[SUM_W-1:0];
			end
		end
		return nx;
	endfunction

	logic [DIV_W-1:0] d;
	logic advance;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	div_t div_s1, div_s2, div_s3, div_s4;
	div_t load;

	// Divisor 0 or 1 passes the sum through as a division by one.
	assign d       = (sum_divisor < DIV_W'(2)) ? DIV_W'(1) : sum_divisor;
	assign advance = !valid_s4 || filtered.ready;
	assign pop     = advance && head.valid;
	assign load    = '{rem: '0, nq: head.sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			div_s1 <= div_step2(load, d);
			div_s2 <= div_step2(div_s1, d);
			div_s3 <= div_step2(div_s2, d);
			div_s4 <= div_step2(div_s3, d);
		end
	end

	assign filtered.valid          = valid_s4;
	assign filtered.filtered_pixel = div_s4.nq;

endmodule

// ===== test/tb_pixel_convolution_3x3_core.sv =====
// Self-checking testbench for the 3x3 pixel convolution core.
`timescale 1ns / 1ps

module tb_pixel_convolution_3x3_core import pc3_pkg::*; ();

	localparam int RING_DEPTH = 2 * MAX_COLS_DEF + 3;
	localparam int RANDOM_PIXELS = 700;
	// Cycles to let the pipeline settle once nothing is expected any more.
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LAST  = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             image_start;
	} pixel_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	pc3_pixel_if  pix_bus ();
	pc3_result_if filt_bus ();

	pixel_convolution_3x3_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_bus),
		.filtered (filt_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Pixels waiting to be offered, and filtered values still owed by the core.
	pixel_req_t   pixel_backlog [$];
	logic [7:0]   pending_filtered [$];

	// Shadow of the register file as the core should see it.
	logic [ROW_W-1:0]  set_row_width;
	logic [KROW_W-1:0] set_kernel [3];
	logic [DIV_W-1:0]  set_divisor;

	// Shadow of the pixel history: intensities of recent pixels and the index
	// of the next pixel within the current image.
	logic [INT_W-1:0] intensity_ring [RING_DEPTH];
	int unsigned      ring_head;
	int unsigned      pixel_index;

	// Traffic shaping state of the sender and the receiver.
	bit          no_idle;
	bit          pix_taken;
	int unsigned send_gap;
	int unsigned ready_gap;
	bit          hold_off_armed;
	bit          hold_off_started;
	int unsigned hold_off_left;

	int unsigned error_count;
	int unsigned results_checked;
	int unsigned queued_pixels;
	int unsigned settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous wall-clock bound; a hung pipeline or a lost result ends here.
	initial begin
		#20_000_000;
		$display("pixel_convolution_3x3_core verification failed");
		$finish;
	end

	// Advance the shadow history by one pixel and queue the filtered value,
	// if this pixel completes a window.
	function automatic void convolve_next(input pixel_req_t req);
		int unsigned w;
		int unsigned top;
		int unsigned idx;
		int unsigned k;
		int unsigned n;
		logic [INT_W-1:0] tap;
		logic [7:0] wbyte;
		int prod;
		logic [7:0] acc;
		// Out-of-range widths clamp: zero acts as one, too wide acts as the maximum.
		if (set_row_width == 0)
			w = 1;
		else if (set_row_width > MAX_COLS_DEF)
			w = MAX_COLS_DEF;
		else
			w = set_row_width;
		top = 2 * w + 2;
		idx = req.image_start ? 0 : pixel_index;
		if (idx > top)
			idx = top;
		ring_head = (ring_head + 1) % RING_DEPTH;
		intensity_ring[ring_head] = req.pixel[7:5];
		pixel_index = (idx < top) ? idx + 1 : top;
		if (idx < w + 1)
			return;
		acc = '0;
		for (int j = 0; j < TAP_NUM; j++) begin
			// Window position j sits (2-row)*W + 2-col pixels back; weights are flipped.
			k = (2 - j / 3) * w + 2 - j % 3;
			tap = (k > idx) ? '0 : intensity_ring[(ring_head + RING_DEPTH - k) % RING_DEPTH];
			n = 8 - j;
			wbyte = set_kernel[n / 3][8 * (n % 3) +: 8];
			prod = int'(tap) * int'($signed(wbyte));
			acc = acc + prod[7:0];
		end
		if (set_divisor >= 2)
			acc = acc / set_divisor;
		pending_filtered.push_back(acc);
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'hFF;
			3: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] pick_kernel_row();
		return {pick_weight(), pick_weight(), pick_weight()};
	endfunction

	function automatic logic [DIV_W-1:0] pick_divisor();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1, 2: return 8'd1;
			3: return 8'd2;
			4: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] pick_row_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return ROW_W'($urandom_range(1, 8));
		else if (r < 95)
			return ROW_W'($urandom_range(9, 64));
		else if (r < 97)
			return '0;
		return ROW_W'($urandom_range(65, 200));
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 19))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'hE0;
			3: return 8'h1F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned clamp_width(input logic [ROW_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_COLS_DEF)
			return MAX_COLS_DEF;
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
	endtask

	// Load all registers while the core is idle; junk above the row width and divisor is dropped.
	task automatic load_settings(input logic [ROW_W-1:0] w, input logic [KROW_W-1:0] k_top,
			input logic [KROW_W-1:0] k_mid, input logic [KROW_W-1:0] k_bot,
			input logic [DIV_W-1:0] div);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_ROW_WIDTH, {junk[CFG_DATA_W-1:ROW_W], w});
		write_reg(REG_KERNEL_TOP, k_top);
		write_reg(REG_KERNEL_MIDDLE, k_mid);
		write_reg(REG_KERNEL_BOTTOM, k_bot);
		write_reg(REG_SUM_DIVISOR, {junk[CFG_DATA_W-1:DIV_W], div});
		// Unmapped index must be ignored.
		write_reg(CFG_IDX_W'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)), CFG_DATA_W'($urandom));
		@(negedge clk);
		wr_en <= 1'b0;
		set_row_width = w;
		set_kernel[0] = k_top;
		set_kernel[1] = k_mid;
		set_kernel[2] = k_bot;
		set_divisor = div;
		settings_used++;
	endtask

	task automatic queue_pixel(input logic [PIX_W-1:0] px, input logic start);
		pixel_req_t req;
		req.pixel = px;
		req.image_start = start;
		pixel_backlog.push_back(req);
		queued_pixels++;
	endtask

	// One image of random content; when noisy, a rare stray image_start breaks it up.
	task automatic queue_image(input int unsigned len, input logic start, input bit noisy);
		for (int unsigned i = 0; i < len; i++)
			queue_pixel(pick_pixel(), (i == 0) ? start : (noisy && $urandom_range(0, 99) == 0));
	endtask

	// Zero padding that pushes the last row of centres out.
	task automatic queue_flush(input int unsigned w);
		for (int unsigned i = 0; i < w + 1; i++)
			queue_pixel(8'h00, 1'b0);
	endtask

	// Drain: everything offered and every result back, then let trailing
	// pixels that produce no result finish inside the core.
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pending_filtered.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: hold an offered request until taken, then maybe idle a while.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
		end else if (pix_bus.valid && !pix_taken) begin
			// hold the current request
		end else begin
			pix_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				pix_bus.valid <= 1'b0;
			end else if (pixel_backlog.size() != 0) begin
				pix_bus.valid <= 1'b1;
				pix_bus.pixel <= pixel_backlog[0].pixel;
				pix_bus.image_start <= pixel_backlog[0].image_start;
				if (!no_idle && $urandom_range(0, 3) == 0)
					send_gap = idle_len();
			end else begin
				pix_bus.valid <= 1'b0;
			end
		end
	end

	// Accept side of the pixel channel: predict on every taken request.
	always @(posedge clk) begin
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			convolve_next(pixel_backlog.pop_front());
			pix_taken = 1'b1;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the core up.
	always @(negedge clk) begin
		if (!arst_n) begin
			filt_bus.ready <= 1'b0;
		end else begin
			if (hold_off_armed && !hold_off_started) begin
				hold_off_started = 1'b1;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				filt_bus.ready <= 1'b0;
			end else if (no_idle) begin
				filt_bus.ready <= 1'b1;
			end else if (ready_gap > 0) begin
				ready_gap--;
				filt_bus.ready <= 1'b0;
			end else begin
				filt_bus.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					ready_gap = idle_len();
			end
		end
	end

	// Monitor: compare each taken result with the oldest owed value.
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && filt_bus.valid && filt_bus.ready) begin
			if (pending_filtered.size() == 0) begin
				$error("filtered_pixel unexpected: expected none actual %0d",
					filt_bus.filtered_pixel);
				error_count++;
			end else begin
				want = pending_filtered.pop_front();
				if (filt_bus.filtered_pixel !== want) begin
					$error("filtered_pixel mismatch: expected %0d actual %0d",
						want, filt_bus.filtered_pixel);
					error_count++;
				end
				results_checked++;
			end
		end
	end

	initial begin
		logic [ROW_W-1:0] w;
		int unsigned eff;
		int unsigned start_count;
		int unsigned len;

		// Drive every input to a known value from time zero.
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		pix_bus.image_start = 1'b0;
		filt_bus.ready = 1'b0;
		no_idle = 1'b0;
		pix_taken = 1'b0;
		send_gap = 0;
		ready_gap = 0;
		hold_off_armed = 1'b0;
		hold_off_started = 1'b0;
		hold_off_left = 0;
		error_count = 0;
		results_checked = 0;
		queued_pixels = 0;
		settings_used = 0;

		// Register defaults and an empty history, as after reset.
		set_row_width = ROW_W'(MAX_COLS_DEF);
		set_kernel[0] = '0;
		set_kernel[1] = '0;
		set_kernel[2] = '0;
		set_divisor = 8'd1;
		ring_head = 0;
		pixel_index = 0;
		for (int i = 0; i < RING_DEPTH; i++)
			intensity_ring[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: two-pixel rows with extreme weights mixed in. The first image
		// after reset starts without image_start; a restart follows mid-stream.
		load_settings(11'd2, {8'h7F, 8'h80, 8'hFF}, {8'h01, 8'h7F, 8'h80},
			{8'h80, 8'h02, 8'hFF}, 8'd1);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'hE0, 1'b0);
		queue_pixel(8'h1F, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		for (int i = 1; i < 7; i++)
			queue_pixel(8'(i << 5), 1'b0);
		queue_pixel(8'hFF, 1'b1);
		queue_pixel(8'h00, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h7F, 1'b0);
		queue_flush(2);
		wait_idle();

		// Directed: zero width acts as one, zero divisor means no division.
		load_settings(11'd0, {3{8'h80}}, {3{8'h80}}, {3{8'h80}}, 8'd0);
		queue_pixel(8'hFF, 1'b1);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'hE0, 1'b0);
		queue_flush(1);
		wait_idle();

		// Back-pressure: a long burst against a receiver that holds off.
		start_count = queued_pixels;
		load_settings(11'd3, pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
			pick_divisor());
		no_idle = 1'b1;
		queue_image(200, 1'b1, 1'b0);
		queue_flush(3);
		hold_off_armed = 1'b1;
		wait_idle();

		// Random settings, mostly narrow rows; some images continue across a
		// change of settings, some are too short to give any result.
		while (queued_pixels - start_count < RANDOM_PIXELS) begin
			w = pick_row_width();
			eff = clamp_width(w);
			load_settings(w, pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
				pick_divisor());
			no_idle = ($urandom_range(0, 4) == 0);
			for (int img = 0; img < $urandom_range(1, 3); img++) begin
				if ($urandom_range(0, 99) < 15)
					len = $urandom_range(1, eff);
				else
					len = $urandom_range(eff + 1, 6 * eff + 12);
				queue_image(len, (img != 0) || ($urandom_range(0, 5) != 0), 1'b1);
			end
			queue_flush(eff);
			wait_idle();
		end

		// Width beyond the maximum clamps to full rows; enough pixels for a few
		// dozen results.
		no_idle = 1'b0;
		load_settings({ROW_W{1'b1}}, pick_kernel_row(), pick_kernel_row(),
			pick_kernel_row(), pick_divisor());
		queue_image(MAX_COLS_DEF + 1 + $urandom_range(30, 60), 1'b1, 1'b0);
		wait_idle();

		$display("Streamed %0d pixels under %0d register settings (widths 0 to 2047).",
			queued_pixels, settings_used);
		$display("Compared %0d filtered pixels, with one long output hold-off.",
			results_checked);
		if (error_count == 0)
			$display("pixel_convolution_3x3_core verification clean");
		else
			$display("pixel_convolution_3x3_core verification failed");
		$finish;
	end

endmodule
